// File: hdl/tfr_pkg.sv
// shared types, constants and the crc-8 step function of the telemetry frame receiver
// no dependencies
`default_nettype none

package tfr_pkg;

   // frame layout
   localparam logic [7:0] HDR_FIRST   = 8'hAA;
   localparam logic [7:0] HDR_SECOND  = 8'hBB;
   localparam logic [7:0] FOOTER_BYTE = 8'hEE;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_MSB     = 8'h80;

   localparam int NUM_WORDS      = 6;
   localparam int WORD_ADDR_BITS = 3;
   localparam int CNT_BITS       = 5;

   localparam logic [CNT_BITS-1:0] CNT_AFTER_HDR1 = 5'd1;
   localparam logic [CNT_BITS-1:0] CNT_BODY_START = 5'd2;
   localparam logic [CNT_BITS-1:0] CNT_CRC_SPAN   = 5'd26;

   localparam logic [1:0] LANE_LAST = 2'd3;
   localparam logic [WORD_ADDR_BITS-1:0] WORD_LAST = 3'd5;
   localparam logic [WORD_ADDR_BITS:0]   PTR_END   = 4'd6;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HDR_TIMEOUT  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BODY_TIMEOUT = 1'b1;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_DATA_BITS-1:0] HDR_TIMEOUT_RESET  = 16'd10;
   localparam logic [CSR_DATA_BITS-1:0] BODY_TIMEOUT_RESET = 16'd50;

   // input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HDR  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // completed payload word going to the word memory
   typedef struct packed {
      logic                      en;
      logic [WORD_ADDR_BITS-1:0] addr;
      logic [31:0]               data;
   } word_wr_type;

   // end of a frame with a good footer
   typedef struct packed {
      logic valid;
      logic crc_bad;
   } frame_done_type;

   // readout progress seen by the deframer for its interlock
   typedef struct packed {
      logic                    busy;
      logic [WORD_ADDR_BITS:0] ptr;
   } rdo_status_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/telemetry_frame_receiver_unit.sv
// top level of the telemetry frame receiver: configuration registers, deframer,
// word memory and result readout; depends on tfr_pkg, tfr_ram, tfr_deframer, tfr_readout
`default_nettype none

// Takes one transaction per clock on the req_ channel: either a received serial
// byte (command 0) or one elapsed time tick (command 1). Frames of 28 bytes
// (0xAA, 0xBB, six little-endian 32-bit words, crc-8 poly 0x07 over the first
// 26 bytes, 0xEE footer) are tracked byte by byte; each completed payload word
// goes into a six-entry word memory. A frame with a good footer yields one
// rsp_ transaction: status 0 with the six raw words, or status 1 with all
// words zero on a checksum mismatch. A bad footer, a wrong second header byte
// or a timeout drops the frame without a result. Rate: one transaction per
// cycle. After the footer the six words are read out of the single memory
// read port one per cycle, held off while the previous result is still waiting
// on rsp_ready. req_ready drops only while a readout is pending and the next
// byte would overwrite a word not yet read or end another frame; with an
// attentive consumer that never happens, since a new frame needs six bytes
// before its first word is written.
// Timeout registers are 0 (header, reset 10 ticks) and 1 (body, reset 50).
module telemetry_frame_receiver_unit #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes
   input  wire logic                               csr_write_enable,
   input  wire logic [tfr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tfr_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   // input transactions
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_command,
   input  wire logic [7:0]                         req_rx_byte,
   // result transactions
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_frame_status,
   output logic [31:0]                             rsp_angle_bits,
   output logic [31:0]                             rsp_speed_bits,
   output logic [31:0]                             rsp_gain_p_bits,
   output logic [31:0]                             rsp_gain_i_bits,
   output logic [31:0]                             rsp_gain_d_bits,
   output logic [31:0]                             rsp_angle_offset_bits
);
   import tfr_pkg::*;

   // timeout registers
   logic [CSR_DATA_BITS-1:0] hdr_timeout_ff, hdr_timeout_in;
   logic [CSR_DATA_BITS-1:0] body_timeout_ff, body_timeout_in;

   word_wr_type               word_wr;
   frame_done_type            frame_done;
   rdo_status_type            rdo_status;
   logic                      rd_en;
   logic [WORD_ADDR_BITS-1:0] rd_addr;
   logic [31:0]               rd_data;

   always_comb begin
      hdr_timeout_in  = hdr_timeout_ff;
      body_timeout_in = body_timeout_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HDR_TIMEOUT:  hdr_timeout_in  = csr_write_data;
            CSR_BODY_TIMEOUT: body_timeout_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_timeout_ff  <= HDR_TIMEOUT_RESET;
         body_timeout_ff <= BODY_TIMEOUT_RESET;
      end else begin
         hdr_timeout_ff  <= hdr_timeout_in;
         body_timeout_ff <= body_timeout_in;
      end
   end

   // header hunt, timeouts, crc and word assembly
   tfr_deframer #(
      .TIMER_BITS (TIMER_BITS)
   ) u_deframer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_rx_byte  (req_rx_byte),
      .hdr_timeout  (hdr_timeout_ff),
      .body_timeout (body_timeout_ff),
      .rdo_status   (rdo_status),
      .word_wr      (word_wr),
      .frame_done   (frame_done)
   );

   // payload word memory, one entry per frame word
   tfr_ram #(
      .WIDTH (32),
      .DEPTH (NUM_WORDS)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_wr.en),
      .wr_addr (word_wr.addr),
      .wr_data (word_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // readout of the six words into the result register
   tfr_readout u_readout (
      .clock                 (clock),
      .reset                 (reset),
      .frame_done            (frame_done),
      .rdo_status            (rdo_status),
      .rd_en                 (rd_en),
      .rd_addr               (rd_addr),
      .rd_data               (rd_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_angle_bits        (rsp_angle_bits),
      .rsp_speed_bits        (rsp_speed_bits),
      .rsp_gain_p_bits       (rsp_gain_p_bits),
      .rsp_gain_i_bits       (rsp_gain_i_bits),
      .rsp_gain_d_bits       (rsp_gain_d_bits),
      .rsp_angle_offset_bits (rsp_angle_offset_bits)
   );

endmodule

`default_nettype wire

// File: hdl/tfr_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module tfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 6
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/tfr_deframer.sv
// byte-level frame tracker: header hunt, timeouts, crc-8, word assembly
// depends on tfr_pkg
`default_nettype none

module tfr_deframer #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [7:0]                        req_rx_byte,
   input  wire logic [tfr_pkg::CSR_DATA_BITS-1:0] hdr_timeout,
   input  wire logic [tfr_pkg::CSR_DATA_BITS-1:0] body_timeout,
   input  wire tfr_pkg::rdo_status_type           rdo_status,
   output tfr_pkg::word_wr_type                   word_wr,
   output tfr_pkg::frame_done_type                frame_done
);
   import tfr_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > CSR_DATA_BITS) ? TIMER_BITS : CSR_DATA_BITS;

   phase_type               phase_ff, phase_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [7:0]              crc_ff, crc_in;
   logic [TIMER_BITS-1:0]   tick_ff, tick_in;
   logic [7:0]              check_ff, check_in;
   logic [23:0]             asm_ff, asm_in;

   logic                      accept;
   logic [CNT_BITS-1:0]       body_k;
   logic [1:0]                lane;
   logic [WORD_ADDR_BITS-1:0] word_idx;
   logic                      in_payload;
   logic                      stall;
   logic [TIMER_BITS-1:0]     tick_sat;
   logic [CSR_DATA_BITS-1:0]  limit;

   assign body_k     = count_ff - CNT_BODY_START;
   assign lane       = body_k[1:0];
   assign word_idx   = body_k[CNT_BITS-1:2];
   assign in_payload = (count_ff < CNT_CRC_SPAN);

   // hold off a byte that would overwrite a word not yet read out, or end a frame
   // while the previous one is still being read out
   assign stall = (phase_ff == PH_BODY) && rdo_status.busy &&
                  ((in_payload && (lane == LANE_LAST) &&
                    ({1'b0, word_idx} >= rdo_status.ptr)) ||
                   (count_ff > CNT_CRC_SPAN));

   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;

   assign tick_sat = (tick_ff == {TIMER_BITS{1'b1}}) ? tick_ff : tick_ff + 1'b1;
   assign limit    = (phase_ff == PH_HDR) ? hdr_timeout : body_timeout;

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      tick_in  = tick_ff;
      check_in = check_ff;
      asm_in   = asm_ff;
      if (accept) begin
         if (req_command == CMD_TICK) begin
            if ((phase_ff == PH_HDR) || (phase_ff == PH_BODY)) begin
               if (CMP_BITS'(tick_sat) >= CMP_BITS'(limit)) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
                  crc_in   = '0;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_sat;
               end
            end
         end else begin
            case (phase_ff)
               PH_HDR: begin
                  if (req_rx_byte == HDR_SECOND) begin
                     phase_in = PH_BODY;
                     count_in = CNT_BODY_START;
                     crc_in   = crc8_step(crc_ff, req_rx_byte);
                     tick_in  = '0;
                  end else begin
                     phase_in = PH_HUNT;
                     count_in = '0;
                     crc_in   = '0;
                     tick_in  = '0;
                  end
               end
               PH_BODY: begin
                  if (in_payload) begin
                     crc_in   = crc8_step(crc_ff, req_rx_byte);
                     count_in = count_ff + 1'b1;
                     case (lane)
                        2'd0: asm_in[7:0]   = req_rx_byte;
                        2'd1: asm_in[15:8]  = req_rx_byte;
                        2'd2: asm_in[23:16] = req_rx_byte;
                        default: asm_in = asm_ff;
                     endcase
                  end else if (count_ff == CNT_CRC_SPAN) begin
                     check_in = req_rx_byte;
                     count_in = count_ff + 1'b1;
                  end else begin
                     phase_in = PH_HUNT;
                     count_in = '0;
                     crc_in   = '0;
                     tick_in  = '0;
                  end
               end
               default: begin
                  if (req_rx_byte == HDR_FIRST) begin
                     phase_in = PH_HDR;
                     count_in = CNT_AFTER_HDR1;
                     crc_in   = crc8_step(8'h00, req_rx_byte);
                     tick_in  = '0;
                  end else begin
                     phase_in = PH_HUNT;
                     count_in = '0;
                     crc_in   = '0;
                     tick_in  = '0;
                  end
               end
            endcase
         end
      end
   end

   // outputs toward the word memory and the readout
   always_comb begin
      word_wr.en       = 1'b0;
      word_wr.addr     = word_idx;
      word_wr.data     = {req_rx_byte, asm_ff};
      frame_done.valid = 1'b0;
      frame_done.crc_bad = (crc_ff != check_ff);
      if (accept && (req_command == CMD_BYTE) && (phase_ff == PH_BODY)) begin
         if (in_payload) begin
            word_wr.en = (lane == LANE_LAST);
         end else if (count_ff != CNT_CRC_SPAN) begin
            frame_done.valid = (req_rx_byte == FOOTER_BYTE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         crc_ff   <= '0;
         tick_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      check_ff <= check_in;
      asm_ff   <= asm_in;
   end

endmodule

`default_nettype wire

// File: hdl/tfr_readout.sv
// reads the six payload words out of the word memory into the result register
// depends on tfr_pkg
`default_nettype none

module tfr_readout (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tfr_pkg::frame_done_type              frame_done,
   output tfr_pkg::rdo_status_type                   rdo_status,
   output logic                                      rd_en,
   output logic [tfr_pkg::WORD_ADDR_BITS-1:0]        rd_addr,
   input  wire logic [31:0]                          rd_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_frame_status,
   output logic [31:0]                               rsp_angle_bits,
   output logic [31:0]                               rsp_speed_bits,
   output logic [31:0]                               rsp_gain_p_bits,
   output logic [31:0]                               rsp_gain_i_bits,
   output logic [31:0]                               rsp_gain_d_bits,
   output logic [31:0]                               rsp_angle_offset_bits
);
   import tfr_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      bad_ff, bad_in;
   logic                      status_ff, status_in;
   logic [WORD_ADDR_BITS:0]   ptr_ff, ptr_in;
   logic                      ld_vld_ff, ld_vld_in;
   logic [WORD_ADDR_BITS-1:0] ld_idx_ff, ld_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               words_ff [NUM_WORDS];
   logic                      last_load;

   // reads start only once the result register is free
   assign rd_en     = busy_ff && (ptr_ff != PTR_END) && !rsp_valid_ff;
   assign rd_addr   = ptr_ff[WORD_ADDR_BITS-1:0];
   assign last_load = ld_vld_ff && (ld_idx_ff == WORD_LAST);

   assign rdo_status.busy = busy_ff;
   assign rdo_status.ptr  = ptr_ff;

   always_comb begin
      busy_in      = busy_ff;
      bad_in       = bad_ff;
      status_in    = status_ff;
      ptr_in       = ptr_ff;
      ld_vld_in    = rd_en;
      ld_idx_in    = rd_addr;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_en) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (last_load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         status_in    = bad_ff;
      end
      if (frame_done.valid) begin
         busy_in = 1'b1;
         bad_in  = frame_done.crc_bad;
         ptr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ptr_ff       <= '0;
         ld_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         ld_vld_ff    <= ld_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status of the waiting result is held apart from the next frame's status
   always_ff @(posedge clock) begin
      bad_ff    <= bad_in;
      status_ff <= status_in;
      ld_idx_ff <= ld_idx_in;
      if (ld_vld_ff) begin
         words_ff[ld_idx_ff] <= bad_ff ? 32'h0 : rd_data;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_status      = status_ff;
   assign rsp_angle_bits        = words_ff[0];
   assign rsp_speed_bits        = words_ff[1];
   assign rsp_gain_p_bits       = words_ff[2];
   assign rsp_gain_i_bits       = words_ff[3];
   assign rsp_gain_d_bits       = words_ff[4];
   assign rsp_angle_offset_bits = words_ff[5];

endmodule

`default_nettype wire
